// ----- rtl/core/isb_pkg.sv -----
`timescale 1ns / 1ps

package isb_pkg;

  localparam int KIND_W   = 2;
  localparam int POS_W    = 5;
  localparam int HANDLE_W = 16;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Shift command for the entry cells, qualified by the execute decision
  typedef struct packed {
    logic                ins;
    logic                rem;
    logic [POS_W-1:0]    pos;
    logic [HANDLE_W-1:0] handle;
  } cell_cmd_t;

endpackage

// ----- rtl/core/isb_cell_array.sv -----
`timescale 1ns / 1ps

module isb_cell_array #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  isb_pkg::cell_cmd_t                 cmd,
  input  logic [isb_pkg::POS_W-1:0]          rd_pos,
  output logic [isb_pkg::HANDLE_W-1:0]       rd_data
);

  import isb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;
  // Only positions reachable by the index field need a read path
  localparam int RD = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  logic [HANDLE_W-1:0] entries_r [DEPTH];
  logic [IW-1:0]       pos_x;

  assign pos_x = IW'(cmd.pos);

  // Each cell looks only at its neighbors and compares its own index
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HANDLE_W-1:0] cell_nxt;

    always_comb begin
      cell_nxt = entries_r[i];
      if (cmd.ins) begin
        if (IW'(i) == pos_x) begin
          cell_nxt = cmd.handle;
        end else if (IW'(i) > pos_x) begin
          cell_nxt = entries_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.rem) begin
        if ((IW'(i) >= pos_x) && (i < DEPTH - 1)) begin
          cell_nxt = entries_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk) begin
      entries_r[i] <= cell_nxt;
    end
  end

  always_comb begin
    rd_data = '0;
    for (int j = 0; j < RD; j++) begin
      if (rd_pos == POS_W'(j)) begin
        rd_data = entries_r[j];
      end
    end
  end

endmodule

// ----- rtl/core/indexed_sequence_buffer.sv -----
`timescale 1ns / 1ps

// Ordered buffer of up to DEPTH 16-bit handles with read, insert and remove
// by index, and clear. One request is taken every cycle while in_stall is
// low; the request register loads at the accepting edge, one pass through
// the entry cells follows, where the cells at and above the index shift from
// their neighbors while the others hold, and the result register loads when
// the request executes and holds under out_stall. Entries hold unknown data
// after reset and no clearing pass is run; only entries below the count are
// ever returned. occupancy carries the low five bits of the count.
module indexed_sequence_buffer #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [isb_pkg::KIND_W-1:0]    in_kind,
  input  logic [isb_pkg::POS_W-1:0]     in_position,
  input  logic [isb_pkg::HANDLE_W-1:0]  in_handle_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [isb_pkg::HANDLE_W-1:0]  out_handle_out,
  output logic [isb_pkg::STAT_W-1:0]    out_status,
  output logic [isb_pkg::OCC_W-1:0]     out_occupancy
);

  import isb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;

  logic                s1_valid_r;
  kind_t               s1_kind_r;
  logic [POS_W-1:0]    s1_pos_r;
  logic [HANDLE_W-1:0] s1_handle_r;

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;

  logic                out_valid_r;
  logic [HANDLE_W-1:0] out_handle_r;
  status_t             out_status_r;
  logic [OCC_W-1:0]    out_occ_r;

  logic                advance;
  logic                exec;
  logic [IW-1:0]       pos_x;
  logic [IW-1:0]       cnt_x;
  logic                full;
  status_t             status_nxt;
  logic [HANDLE_W-1:0] handle_nxt;
  logic [HANDLE_W-1:0] rd_data;
  cell_cmd_t           cmd;

  assign advance  = !out_valid_r || !out_stall;
  assign exec     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_kind_r   <= kind_t'(in_kind);
      s1_pos_r    <= in_position;
      s1_handle_r <= in_handle_in;
    end
  end

  assign pos_x = IW'(s1_pos_r);
  assign cnt_x = IW'(count_r);
  assign full  = (count_r == CW'(DEPTH));

  always_comb begin
    status_nxt = ST_OK;
    handle_nxt = '0;
    count_nxt  = count_r;
    cmd        = '{ins: 1'b0, rem: 1'b0, pos: s1_pos_r, handle: s1_handle_r};
    unique case (s1_kind_r)
      KIND_READ: begin
        if (pos_x >= cnt_x) begin
          status_nxt = ST_RANGE;
        end else begin
          handle_nxt = rd_data;
        end
      end
      KIND_INSERT: begin
        priority if (pos_x > cnt_x) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins   = exec;
          count_nxt = CW'(count_r + 1'b1);
        end
      end
      KIND_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status_nxt = ST_RANGE;
        end else begin
          handle_nxt = rd_data;
          cmd.rem    = exec;
          count_nxt  = CW'(count_r - 1'b1);
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  isb_cell_array #(
    .DEPTH(DEPTH)
  ) u_cells (
    .clk    (clk),
    .cmd    (cmd),
    .rd_pos (s1_pos_r),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        count_r <= count_nxt;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_handle_r <= handle_nxt;
      out_status_r <= status_nxt;
      out_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_status     = out_status_r;
  assign out_occupancy  = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count exceeds depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (s1_kind_r == KIND_CLEAR) |=> count_r == '0)
    else $error("clear did not empty the buffer");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (s1_kind_r != KIND_CLEAR) |=>
      (count_r == $past(count_r)) ||
      (count_r == CW'($past(count_r) + 1'b1)) ||
      (count_r == CW'($past(count_r) - 1'b1)))
    else $error("count moved by more than one");

  a_occ_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_occ_r == OCC_W'(count_r))
    else $error("reported occupancy disagrees with count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> out_handle_r == '0)
    else $error("nonzero handle on error status");

endmodule
